// ===== design/srw_pkg.sv =====
// ----------------------------------------------------------------------------
// srw_pkg
// Shared types and constants of the selective-repeat receive window.
// ----------------------------------------------------------------------------
package srw_pkg;

  // Window store depth and bytes per frame slot
  localparam int MAX_WINDOW    = 32;
  localparam int PAYLOAD_BYTES = 1024;

  // Field widths
  localparam int SEQ_W    = 16;
  localparam int LEN_W    = 11;
  localparam int OFFS_W   = 26;
  localparam int BYTES_W  = 27;
  localparam int COUNT_W  = 17;
  localparam int FPB_W    = 16;
  localparam int WCFG_W   = 6;
  localparam int WIN_W    = $clog2(MAX_WINDOW + 1);

  // Configuration port
  localparam int CFG_INDEX_W = 4;
  localparam int CFG_DATA_W  = 16;

  // Register reset values
  localparam int WINDOW_RESET = 8;
  localparam int FPB_RESET    = 256;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_WINDOW_SIZE       = 4'd0,
    REG_FRAMES_PER_BUFFER = 4'd1
  } cfg_reg_t;

  // Arriving frame header
  typedef struct packed {
    logic [SEQ_W-1:0] seq_num;
    logic [LEN_W-1:0] payload_len;
    logic             frame_bad;
    logic             end_mark;
  } frame_t;

  // Acknowledgement and buffer report
  typedef struct packed {
    logic [SEQ_W-1:0]   ack_seq;
    logic               ack_good;
    logic               store_enable;
    logic [OFFS_W-1:0]  store_offset;
    logic               buffer_complete;
    logic [BYTES_W-1:0] buffer_bytes;
    logic               transfer_done;
  } result_t;

  // Classified header handed from front to back
  typedef struct packed {
    logic [SEQ_W-1:0]   seq;
    logic               good;
    logic               eot;
    logic [OFFS_W-1:0]  offset;
    logic [BYTES_W-1:0] end_bytes;
  } mid_item_t;

  // Configuration seen by the back end
  typedef struct packed {
    logic [WIN_W-1:0] window;
    logic [FPB_W-1:0] fpb;
    logic             fpb_load;
  } cfg_t;

  // Byte count of a full buffer of the given frame count
  function automatic logic [BYTES_W-1:0] full_bytes(input logic [FPB_W-1:0] fpb);
    full_bytes = BYTES_W'(48'(fpb) * 48'(PAYLOAD_BYTES));
  endfunction

endpackage

// ===== design/selective_repeat_receive_window.sv =====
// ----------------------------------------------------------------------------
// selective_repeat_receive_window
// Receiver side of a selective-repeat sliding window: acknowledges every
// frame header, directs payload storage, and reports completed buffers.
//
//   Channel   Handshake              Payload
//   -------   --------------------   -----------------------------------
//   frame     push / full            frame_t  (seq, len, bad, end mark)
//   result    empty / pop            result_t (ack, store, buffer report)
//   config    cfg_wen                cfg_index, cfg_data
//
// One header per cycle sustained while results are popped; an accepted
// header waits in the front queue until the window update takes it, and
// its result enters the result queue with the new window state, ready to
// pop. The window update is a find-first-zero and shift over the mark
// flags. Reset is synchronous and needs no clearing pass. Either side may
// stall: two-entry queues decouple input, window logic and result delivery.
// ----------------------------------------------------------------------------
module selective_repeat_receive_window
  import srw_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  output logic                   full,
  input  frame_t                 frame,
  output logic                   empty,
  input  logic                   pop,
  output result_t                result,
  input  logic                   cfg_wen,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  logic [WCFG_W-1:0] window_reg;
  logic [FPB_W-1:0]  frames_per_buffer;
  logic              wsize_wr;
  logic              fpb_wr;
  cfg_t              cfg;
  logic              mid_valid;
  logic              mid_take;
  mid_item_t         mid_item;

  // Decode register writes
  always_comb begin
    wsize_wr = 1'b0;
    fpb_wr   = 1'b0;
    if (cfg_wen) begin
      unique case (cfg_index)
        REG_WINDOW_SIZE:       wsize_wr = 1'b1;
        REG_FRAMES_PER_BUFFER: fpb_wr   = 1'b1;
        default: begin
          wsize_wr = 1'b0;
          fpb_wr   = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_reg        <= WCFG_W'(WINDOW_RESET);
      frames_per_buffer <= FPB_W'(FPB_RESET);
    end else begin
      if (wsize_wr) window_reg        <= cfg_data[WCFG_W-1:0];
      if (fpb_wr)   frames_per_buffer <= cfg_data[FPB_W-1:0];
    end
  end

  // Clamp the window into range, pass a new frame count straight through
  always_comb begin
    if (window_reg == '0) begin
      cfg.window = WIN_W'(1);
    end else if (32'(window_reg) > MAX_WINDOW) begin
      cfg.window = WIN_W'(MAX_WINDOW);
    end else begin
      cfg.window = WIN_W'(window_reg);
    end
    cfg.fpb      = fpb_wr ? cfg_data[FPB_W-1:0] : frames_per_buffer;
    cfg.fpb_load = fpb_wr;
  end

  srw_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .frame     (frame),
    .mid_valid (mid_valid),
    .mid_take  (mid_take),
    .mid_item  (mid_item)
  );

  srw_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .mid_valid (mid_valid),
    .mid_take  (mid_take),
    .mid_item  (mid_item),
    .empty     (empty),
    .pop       (pop),
    .result    (result)
  );

endmodule

// ===== design/srw_front.sv =====
// ----------------------------------------------------------------------------
// srw_front
// Accepts frame headers, works out offset and end byte count, and holds
// them in a two-entry queue toward the window logic.
// ----------------------------------------------------------------------------
module srw_front
  import srw_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  output logic      full,
  input  frame_t    frame,
  output logic      mid_valid,
  input  logic      mid_take,
  output mid_item_t mid_item
);

  mid_item_t        entries [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;
  logic             do_push;
  logic             do_pop;
  mid_item_t        classified;
  logic [LEN_W-1:0] len_clamped;

  // Classify the incoming header
  always_comb begin
    if (32'(frame.payload_len) > PAYLOAD_BYTES) begin
      len_clamped = LEN_W'(PAYLOAD_BYTES);
    end else begin
      len_clamped = frame.payload_len;
    end
    classified.seq       = frame.seq_num;
    classified.good      = !frame.frame_bad;
    classified.eot       = frame.end_mark;
    classified.offset    = OFFS_W'(32'(frame.seq_num) * PAYLOAD_BYTES);
    classified.end_bytes = BYTES_W'(classified.offset) + BYTES_W'(len_clamped);
  end

  assign full      = (count == 2'd2);
  assign mid_valid = (count != 2'd0);
  assign do_push   = push && !full;
  assign do_pop    = mid_take && mid_valid;
  assign mid_item  = entries[rd_ptr];

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= !wr_ptr;
      if (do_pop)  rd_ptr <= !rd_ptr;
      count <= count + 2'(do_push) - 2'(do_pop);
    end
  end

  // Hold queued headers
  always_ff @(posedge clk) begin
    if (do_push) entries[wr_ptr] <= classified;
  end

endmodule

// ===== design/srw_back.sv =====
// ----------------------------------------------------------------------------
// srw_back
// Window state: marks frames received, slides the window, tracks buffer
// completion, and queues one result per header in a two-entry queue.
// ----------------------------------------------------------------------------
module srw_back
  import srw_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  cfg_t      cfg,
  input  logic      mid_valid,
  output logic      mid_take,
  input  mid_item_t mid_item,
  output logic      empty,
  input  logic      pop,
  output result_t   result
);

  logic [COUNT_W-1:0]    next_expected;
  logic [MAX_WINDOW-1:0] marks;
  logic [COUNT_W-1:0]    frame_limit;
  logic [BYTES_W-1:0]    pending_bytes;
  logic                  last_seen;

  logic [COUNT_W-1:0]    next_expected_next;
  logic [MAX_WINDOW-1:0] marks_next;
  logic [COUNT_W-1:0]    frame_limit_next;
  logic [BYTES_W-1:0]    pending_bytes_next;
  logic                  last_seen_next;

  logic [COUNT_W:0]      window_end;
  logic                  in_window;
  logic                  is_next;
  logic                  is_ahead;
  logic [COUNT_W-1:0]    distance;
  logic [WIN_W-1:0]      shift;
  logic                  untouched;
  result_t               res;

  result_t               entries [2];
  logic                  wr_ptr;
  logic                  rd_ptr;
  logic [1:0]            count;
  logic                  out_full;
  logic                  do_pop;

  assign out_full = (count == 2'd2);
  assign mid_take = mid_valid && !out_full;
  assign empty    = (count == 2'd0);
  assign do_pop   = pop && !empty;
  assign result   = entries[rd_ptr];

  assign untouched = (next_expected == '0) && !last_seen && (marks == '0);

  // Classify against the window
  always_comb begin
    window_end = {1'b0, next_expected} + (COUNT_W + 1)'(cfg.window);
    in_window  = mid_item.good && ((COUNT_W + 1)'(mid_item.seq) < window_end);
    is_next    = (COUNT_W'(mid_item.seq) == next_expected);
    is_ahead   = (COUNT_W'(mid_item.seq) > next_expected);
    distance   = COUNT_W'(mid_item.seq) - next_expected;
  end

  // Find the first frame not yet received above the in-order one
  always_comb begin
    shift = cfg.window;
    for (int i = MAX_WINDOW - 1; i >= 1; i--) begin
      if ((i < 32'(cfg.window)) && !marks[i]) shift = WIN_W'(i);
    end
  end

  // Carry out one header
  always_comb begin
    next_expected_next = next_expected;
    marks_next         = marks;
    frame_limit_next   = frame_limit;
    pending_bytes_next = pending_bytes;
    last_seen_next     = last_seen;

    res.ack_seq         = mid_item.seq;
    res.ack_good        = mid_item.good;
    res.store_enable    = 1'b0;
    res.store_offset    = '0;
    res.buffer_complete = 1'b0;
    res.buffer_bytes    = '0;
    res.transfer_done   = 1'b0;

    if (in_window) begin
      priority if (is_next) begin
        res.store_enable   = 1'b1;
        marks_next         = marks >> shift;
        next_expected_next = next_expected + COUNT_W'(shift);
      end else if (is_ahead) begin
        if ((32'(distance) < MAX_WINDOW) &&
            !marks[distance[$clog2(MAX_WINDOW)-1:0]]) begin
          res.store_enable = 1'b1;
          marks_next[distance[$clog2(MAX_WINDOW)-1:0]] = 1'b1;
        end
      end else begin
        // duplicate below the window: acknowledge without storing
        res.store_enable = 1'b0;
      end
      if (mid_item.eot) begin
        pending_bytes_next = mid_item.end_bytes;
        frame_limit_next   = COUNT_W'(mid_item.seq) + COUNT_W'(1);
        last_seen_next     = 1'b1;
      end
    end

    if (res.store_enable) res.store_offset = mid_item.offset;

    // Report the buffer and open a fresh window
    if (next_expected_next >= frame_limit_next) begin
      res.buffer_complete = 1'b1;
      res.buffer_bytes    = pending_bytes_next;
      res.transfer_done   = last_seen_next;
      next_expected_next  = '0;
      marks_next          = '0;
      frame_limit_next    = COUNT_W'(cfg.fpb);
      pending_bytes_next  = full_bytes(cfg.fpb);
      last_seen_next      = 1'b0;
    end
  end

  // Update window state
  always_ff @(posedge clk) begin
    if (rst) begin
      next_expected <= '0;
      marks         <= '0;
      frame_limit   <= COUNT_W'(FPB_RESET);
      pending_bytes <= full_bytes(FPB_W'(FPB_RESET));
      last_seen     <= 1'b0;
    end else if (mid_take) begin
      next_expected <= next_expected_next;
      marks         <= marks_next;
      frame_limit   <= frame_limit_next;
      pending_bytes <= pending_bytes_next;
      last_seen     <= last_seen_next;
    end else if (cfg.fpb_load && untouched) begin
      frame_limit   <= COUNT_W'(cfg.fpb);
      pending_bytes <= full_bytes(cfg.fpb);
    end
  end

  // Advance result queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (mid_take) wr_ptr <= !wr_ptr;
      if (do_pop)   rd_ptr <= !rd_ptr;
      count <= count + 2'(mid_take) - 2'(do_pop);
    end
  end

  // Hold queued results
  always_ff @(posedge clk) begin
    if (mid_take) entries[wr_ptr] <= res;
  end

  // A taken header always leaves a result waiting
  a_result_after_take: assert property (@(posedge clk) disable iff (rst)
    mid_take |=> !empty)
    else $error("result missing after header taken");

  // A completed buffer leaves a fresh window behind
  a_fresh_after_complete: assert property (@(posedge clk) disable iff (rst)
    (mid_take && res.buffer_complete) |=> (next_expected == '0 && !last_seen))
    else $error("window not reset after buffer completion");

  // Only good frames are stored
  a_store_good: assert property (@(posedge clk) disable iff (rst)
    (mid_take && res.store_enable) |-> res.ack_good)
    else $error("bad frame stored");

  // Result queue never overflows
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    out_full |-> !mid_take)
    else $error("result queue overflow");

endmodule

// ===== test/selective_repeat_receive_window_test.sv =====
// ----------------------------------------------------------------------------
// selective_repeat_receive_window_test
// Self-checking bench for the selective-repeat receive window. A directed
// opening covers duplicates, out-of-order marking, bad frames, oversized
// payloads, window clamping, zero and maximum buffer sizes and deferred
// buffer-size writes. Random phases then run mostly well-formed frame streams
// steered off the live window state, mixed with noise, under several idling
// profiles and one long receiver hold-off. A scoreboard predicts every
// acknowledgement and buffer report and checks each result beat in order.
// ----------------------------------------------------------------------------
module selective_repeat_receive_window_test;
  timeunit 1ns;
  timeprecision 1ps;

  import srw_pkg::*;

  localparam int STALL_LIMIT     = 3000;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int PHASE_COUNT     = 8;
  localparam int PHASE_FRAMES    = 238;
  localparam int DRAIN_CYCLES    = 8;

  // index that maps to no register
  localparam logic [CFG_INDEX_W-1:0] UNMAPPED_REG = 4'd7;

  // Window and buffer tracker: predicts one result per accepted frame header
  class window_scoreboard;
    bit [WCFG_W-1:0]  window_reg;
    bit [FPB_W-1:0]   fpb_reg;
    bit [COUNT_W-1:0] next_exp;
    bit               marks [MAX_WINDOW];
    bit [COUNT_W-1:0] limit;
    bit [BYTES_W-1:0] pend_bytes;
    bit               last_seen;
    result_t          expected_q [$];
    int               errors;

    function new();
      window_reg = WCFG_W'(WINDOW_RESET);
      fpb_reg    = FPB_W'(FPB_RESET);
      errors     = 0;
      open_buffer();
    endfunction

    // Clear window and marks, reload the buffer size
    function void open_buffer();
      next_exp = '0;
      foreach (marks[i]) marks[i] = 1'b0;
      limit      = COUNT_W'(fpb_reg);
      pend_bytes = BYTES_W'(int'(fpb_reg) * PAYLOAD_BYTES);
      last_seen  = 1'b0;
    endfunction

    // Clamp the configured window to 1..MAX_WINDOW
    function int unsigned window_frames();
      if (window_reg == 0) return 1;
      if (window_reg > MAX_WINDOW) return MAX_WINDOW;
      return window_reg;
    endfunction

    function bit untouched();
      if (next_exp != 0 || last_seen) return 1'b0;
      foreach (marks[i]) if (marks[i]) return 1'b0;
      return 1'b1;
    endfunction

    function void set_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      if (idx == REG_WINDOW_SIZE) begin
        window_reg = data[WCFG_W-1:0];
      end else if (idx == REG_FRAMES_PER_BUFFER) begin
        fpb_reg = data;
        if (untouched()) open_buffer();
      end
    endfunction

    function void note_frame(frame_t f);
      int unsigned seq, len, w, shift, idx, offset;
      int          i;
      result_t     r;
      seq    = f.seq_num;
      len    = f.payload_len;
      w      = window_frames();
      offset = seq * PAYLOAD_BYTES;
      r          = '0;
      r.ack_seq  = f.seq_num;
      r.ack_good = !f.frame_bad;
      if (len > PAYLOAD_BYTES) len = PAYLOAD_BYTES;

      if (!f.frame_bad && seq < next_exp + w) begin
        if (seq == next_exp) begin
          // store in-order frame and slide past every marked successor
          r.store_enable = 1'b1;
          shift = 1;
          while (shift < w && marks[shift]) shift++;
          for (i = 0; i < MAX_WINDOW; i++)
            marks[i] = (i + shift < MAX_WINDOW) ? marks[i + shift] : 1'b0;
          next_exp = COUNT_W'(next_exp + shift);
        end else if (seq > next_exp) begin
          // mark out-of-order frame once
          idx = seq - next_exp;
          if (idx < MAX_WINDOW && !marks[idx]) begin
            r.store_enable = 1'b1;
            marks[idx]     = 1'b1;
          end
        end
        if (f.end_mark) begin
          pend_bytes = BYTES_W'(offset + len);
          limit      = COUNT_W'(seq + 1);
          last_seen  = 1'b1;
        end
      end
      if (r.store_enable) r.store_offset = OFFS_W'(offset);

      // report a full buffer and start fresh
      if (next_exp >= limit) begin
        r.buffer_complete = 1'b1;
        r.buffer_bytes    = pend_bytes;
        r.transfer_done   = last_seen;
        open_buffer();
      end
      expected_q.push_back(r);
    endfunction

    task report(string msg);
      if (errors < 100) $display("%0t ns mismatch: %s", $time, msg);
      errors++;
    endtask

    task check_field(string name, logic [15:0] seq, logic [31:0] got, logic [31:0] want);
      if (got !== want)
        report($sformatf("ack %0d %s got 0x%0h want 0x%0h", seq, name, got, want));
    endtask

    task check_result(result_t got);
      result_t want;
      if (expected_q.size() == 0) begin
        report($sformatf("result beat for ack %0d with none expected", got.ack_seq));
        return;
      end
      want = expected_q.pop_front();
      check_field("ack_seq", want.ack_seq, 32'(got.ack_seq), 32'(want.ack_seq));
      check_field("ack_good", want.ack_seq, 32'(got.ack_good), 32'(want.ack_good));
      check_field("store_enable", want.ack_seq, 32'(got.store_enable),
                  32'(want.store_enable));
      check_field("store_offset", want.ack_seq, 32'(got.store_offset),
                  32'(want.store_offset));
      check_field("buffer_complete", want.ack_seq, 32'(got.buffer_complete),
                  32'(want.buffer_complete));
      check_field("buffer_bytes", want.ack_seq, 32'(got.buffer_bytes),
                  32'(want.buffer_bytes));
      check_field("transfer_done", want.ack_seq, 32'(got.transfer_done),
                  32'(want.transfer_done));
    endtask
  endclass

  logic                   clk;
  logic                   rst       = 1'b1;
  logic                   push      = 1'b0;
  logic                   full;
  frame_t                 frame     = '0;
  logic                   empty;
  logic                   pop       = 1'b0;
  result_t                result;
  logic                   cfg_wen   = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data  = '0;

  window_scoreboard sb;
  int send_idle   = 0;
  int recv_stall  = 0;
  int hold_cycles = 0;

  selective_repeat_receive_window DUT (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .frame     (frame),
    .empty     (empty),
    .pop       (pop),
    .result    (result),
    .cfg_wen   (cfg_wen),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic frame_t mk_frame(int seq, int len, bit bad, bit eot);
    frame_t f;
    f.seq_num     = SEQ_W'(seq);
    f.payload_len = LEN_W'(len);
    f.frame_bad   = bad;
    f.end_mark    = eot;
    return f;
  endfunction

  // Pick the next header: mostly frames around the live window, some noise
  function automatic frame_t next_frame();
    frame_t      f;
    int unsigned base, w, span, r;
    r    = $urandom_range(99);
    base = sb.next_exp;
    w    = sb.window_frames();
    span = (sb.limit > base) ? sb.limit - base : 1;
    if (span > w) span = w;
    if (r < 10) begin
      f.seq_num     = SEQ_W'($urandom_range(65535));
      f.payload_len = LEN_W'($urandom_range(2047));
      f.frame_bad   = 1'($urandom_range(1));
      f.end_mark    = 1'($urandom_range(1));
      return f;
    end
    if (r < 45) f.seq_num = SEQ_W'(base);
    else if (r < 55 && base > 0) f.seq_num = SEQ_W'(base - $urandom_range(1, base < 4 ? base : 4));
    else f.seq_num = SEQ_W'(base + $urandom_range(0, span - 1));
    f.payload_len = ($urandom_range(99) < 70) ? LEN_W'(PAYLOAD_BYTES)
                                              : LEN_W'($urandom_range(2047));
    f.frame_bad   = ($urandom_range(99) < 8);
    f.end_mark    = ($urandom_range(99) < 3);
    return f;
  endfunction

  // Offer one frame beat and hold it until accepted; returns at a falling edge
  task send_frame(frame_t f);
    while ($urandom_range(99) < send_idle) begin
      push <= 1'b0;
      @(negedge clk);
    end
    push  <= 1'b1;
    frame <= f;
    do @(posedge clk); while (full);
    sb.note_frame(f);
    @(negedge clk);
  endtask

  // Drop push and wait for every expected result, then let the pipe settle
  task drain();
    push <= 1'b0;
    while (sb.expected_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_wen   <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    sb.set_reg(idx, data);
    cfg_wen <= 1'b0;
    @(negedge clk);
  endtask

  // Result side: random pop, long hold-off on request, check each beat
  initial begin
    while (rst) @(negedge clk);
    forever begin
      if (hold_cycles > 0) begin
        pop <= 1'b0;
        hold_cycles--;
      end else begin
        pop <= ($urandom_range(99) >= recv_stall);
      end
      @(posedge clk);
      if (pop && !empty) sb.check_result(result);
      @(negedge clk);
    end
  end

  // Watchdog: end the run after too many cycles without a beat
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((push && !full) || (pop && !empty) || cfg_wen) quiet = 0;
      else quiet++;
    end
    $display("selective_repeat_receive_window_test: errors");
    $finish;
  end

  initial begin
    int p, n;
    int phase_window [PHASE_COUNT];
    int phase_fpb    [PHASE_COUNT];
    phase_window = '{8, 1, 32, 0, 63, 3, 33, 16};
    phase_fpb    = '{6, 1, 20, 3, 40, 9, 32, 2};
    sb = new();

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Default window: in-order, duplicates, out-of-order marks, slide
    send_frame(mk_frame(0, 0, 0, 0));
    send_frame(mk_frame(0, 5, 0, 0));
    send_frame(mk_frame(3, 1024, 0, 0));
    send_frame(mk_frame(3, 1024, 0, 0));
    send_frame(mk_frame(2, 2047, 0, 0));
    send_frame(mk_frame(1, 1024, 0, 0));
    send_frame(mk_frame(4, 1024, 1, 1));
    send_frame(mk_frame(65535, 2047, 0, 0));
    send_frame(mk_frame(11, 1024, 0, 0));
    send_frame(mk_frame(12, 1024, 0, 0));
    // end mark on a duplicate closes the transfer
    send_frame(mk_frame(2, 100, 0, 1));
    drain();

    // Window zero acts as one; zero frames per buffer completes every beat
    write_reg(REG_WINDOW_SIZE, 16'd0);
    write_reg(REG_FRAMES_PER_BUFFER, 16'd0);
    send_frame(mk_frame(5, 1024, 0, 0));
    send_frame(mk_frame(0, 1024, 1, 1));
    send_frame(mk_frame(0, 1024, 0, 1));
    drain();

    // Oversized window clamps to the store depth; largest buffer
    write_reg(REG_WINDOW_SIZE, 16'h803F);
    write_reg(REG_FRAMES_PER_BUFFER, 16'hFFFF);
    send_frame(mk_frame(31, 1024, 0, 0));
    send_frame(mk_frame(32, 1024, 0, 0));
    send_frame(mk_frame(0, 1024, 0, 0));
    send_frame(mk_frame(32, 700, 0, 1));
    drain();

    // Unknown index is ignored; buffer size on a touched buffer is deferred
    write_reg(UNMAPPED_REG, 16'hFFFF);
    write_reg(REG_FRAMES_PER_BUFFER, 16'd5);

    // Random phases across idling profiles and settings
    for (p = 0; p < PHASE_COUNT; p++) begin
      write_reg(REG_WINDOW_SIZE, CFG_DATA_W'(phase_window[p]));
      write_reg(REG_FRAMES_PER_BUFFER, CFG_DATA_W'(phase_fpb[p]));
      case (p % 4)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 58; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 58; end
        default: begin send_idle = 18; recv_stall = 18; end
      endcase
      // back up the result side so the input stalls
      if (p == 0) hold_cycles = HOLD_OFF_CYCLES;
      for (n = 0; n < PHASE_FRAMES; n++) send_frame(next_frame());
      drain();
    end

    if (sb.errors == 0 && sb.expected_q.size() == 0)
      $display("selective_repeat_receive_window_test: clean");
    else
      $display("selective_repeat_receive_window_test: errors");
    $finish;
  end

endmodule

// ===== filelist.f =====
design/srw_pkg.sv
design/srw_front.sv
design/srw_back.sv
design/selective_repeat_receive_window.sv
test/selective_repeat_receive_window_test.sv
